FILE: rtl/lsb_stego_stream_extractor_macros.svh
// Assertion macros used by the extractor parser.
`ifndef LSB_STEGO_STREAM_EXTRACTOR_MACROS_SVH
`define LSB_STEGO_STREAM_EXTRACTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSSE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lsse_pkg.sv
package lsse_pkg;

  // Bounds of the magic check and of the extension length.
  localparam logic [3:0]  MAGIC_MAX = 4'd8;
  localparam logic [31:0] EXT_MAX   = 32'd9;

  // Reset values of the configuration registers.
  localparam logic [7:0]  HEADER_BYTES_RESET = 8'd54;
  localparam logic [3:0]  MAGIC_LENGTH_RESET = 4'd2;
  localparam logic [63:0] MAGIC_BYTES_RESET  = 64'h0000_0000_0000_2322;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_HEADER_BYTES = 2'd0,
    CFG_MAGIC_LENGTH = 2'd1,
    CFG_MAGIC_BYTES  = 2'd2
  } cfg_index_t;

  // Result kind tags.
  typedef enum logic [2:0] {
    KIND_EXT_LENGTH  = 3'd0,
    KIND_EXT_CHAR    = 3'd1,
    KIND_DATA_LENGTH = 3'd2,
    KIND_DATA_BYTE   = 3'd3,
    KIND_MISMATCH    = 3'd4,
    KIND_EXT_LONG    = 3'd5
  } kind_t;

  // Configuration as seen by the parser.
  typedef struct packed {
    logic [7:0]  header_bytes;
    logic [3:0]  magic_len;
    logic [63:0] magic_bytes;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [31:0] value;
    logic        last;
  } result_t;

endpackage

FILE: rtl/lsse_cfg_regs.sv
module lsse_cfg_regs
  import lsse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output cfg_t        cfg
);

  logic [7:0]  header_bytes;
  logic [3:0]  magic_length;
  logic [63:0] magic_bytes;

  // Register writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= HEADER_BYTES_RESET;
      magic_length <= MAGIC_LENGTH_RESET;
      magic_bytes  <= MAGIC_BYTES_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HEADER_BYTES: header_bytes <= cfg_data[7:0];
        CFG_MAGIC_LENGTH: magic_length <= cfg_data[3:0];
        CFG_MAGIC_BYTES:  magic_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Magic lengths above the bound count as the bound.
  assign cfg.header_bytes = header_bytes;
  assign cfg.magic_len    = (magic_length > MAGIC_MAX) ? MAGIC_MAX : magic_length;
  assign cfg.magic_bytes  = magic_bytes;

endmodule

FILE: rtl/lsse_parser.sv
`include "lsb_stego_stream_extractor_macros.svh"

module lsse_parser
  import lsse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] image_byte,
  input  logic       start_of_image,
  input  cfg_t       cfg,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_MAGIC   = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_EXT     = 3'd3,
    PH_DATALEN = 3'd4,
    PH_DATA    = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  skip_count, skip_count_next;
  logic [4:0]  bit_count, bit_count_next;
  logic [31:0] bit_shift, bit_shift_next;
  logic [3:0]  magic_index, magic_index_next;
  logic        magic_ok, magic_ok_next;
  logic [31:0] remaining, remaining_next;

  // Next parse state and the result of the byte on the input.
  always_comb begin
    logic        go;
    logic        full;
    logic [31:0] v;
    logic [3:0]  sel4;
    logic [5:0]  bit_pos;
    logic [7:0]  want;

    phase_next       = phase;
    skip_count_next  = skip_count;
    bit_count_next   = bit_count;
    bit_shift_next   = bit_shift;
    magic_index_next = magic_index;
    magic_ok_next    = magic_ok;
    remaining_next   = remaining;
    res              = '0;
    res.kind         = KIND_EXT_LENGTH;
    go               = 1'b1;
    full             = 1'b0;
    v                = {bit_shift[30:0], image_byte[0]};
    sel4             = 4'd0;
    bit_pos          = 6'd0;
    want             = 8'd0;

    // A start flag clears the parse before this byte is used.
    if (start_of_image) begin
      phase_next       = PH_HEADER;
      skip_count_next  = 8'd0;
      bit_count_next   = 5'd0;
      bit_shift_next   = 32'd0;
      magic_index_next = 4'd0;
      magic_ok_next    = 1'b1;
      remaining_next   = 32'd0;
      v                = {31'd0, image_byte[0]};
    end

    // Finished parse and header skipping.
    if (phase_next == PH_DONE) begin
      go = 1'b0;
    end else if (phase_next == PH_HEADER) begin
      if (skip_count_next < cfg.header_bytes) begin
        skip_count_next = skip_count_next + 8'd1;
        go = 1'b0;
      end else begin
        phase_next = PH_MAGIC;
      end
    end

    // Magic check already complete: no magic at all, or the length was lowered.
    if (go && phase_next == PH_MAGIC && magic_index_next >= cfg.magic_len) begin
      if (cfg.magic_len == 4'd0 && magic_index_next == 4'd0) begin
        phase_next = PH_EXTLEN;
      end else begin
        go = 1'b0;
        if (!magic_ok_next) begin
          phase_next = PH_DONE;
          res.valid  = 1'b1;
          res.kind   = KIND_MISMATCH;
          res.last   = 1'b1;
        end else begin
          phase_next = PH_EXTLEN;
        end
      end
    end

    // Gather one hidden bit and handle a completed field.
    if (go) begin
      if (phase_next == PH_EXTLEN || phase_next == PH_DATALEN) begin
        full = (bit_count_next == 5'd31);
      end else begin
        full = (bit_count_next == 5'd7);
      end
      if (!full) begin
        bit_shift_next = v;
        bit_count_next = bit_count_next + 5'd1;
      end else begin
        bit_shift_next = 32'd0;
        bit_count_next = 5'd0;
        unique case (phase_next)
          PH_MAGIC: begin
            sel4    = cfg.magic_len - 4'd1 - magic_index_next;
            bit_pos = {sel4[2:0], 3'b000};
            want    = cfg.magic_bytes[bit_pos +: 8];
            if (v[7:0] != want) begin
              magic_ok_next = 1'b0;
            end
            magic_index_next = magic_index_next + 4'd1;
            if (magic_index_next >= cfg.magic_len) begin
              if (!magic_ok_next) begin
                phase_next = PH_DONE;
                res.valid  = 1'b1;
                res.kind   = KIND_MISMATCH;
                res.last   = 1'b1;
              end else begin
                phase_next = PH_EXTLEN;
              end
            end
          end
          PH_EXTLEN: begin
            res.valid = 1'b1;
            if (v > EXT_MAX) begin
              phase_next = PH_DONE;
              res.kind   = KIND_EXT_LONG;
              res.last   = 1'b1;
            end else begin
              remaining_next = v;
              phase_next     = (v == 32'd0) ? PH_DATALEN : PH_EXT;
              res.value      = v;
            end
          end
          PH_EXT: begin
            remaining_next = remaining_next - 32'd1;
            if (remaining_next == 32'd0) begin
              phase_next = PH_DATALEN;
            end
            res.valid = 1'b1;
            res.kind  = KIND_EXT_CHAR;
            res.value = {24'd0, v[7:0]};
          end
          PH_DATALEN: begin
            remaining_next = v;
            res.valid      = 1'b1;
            res.kind       = KIND_DATA_LENGTH;
            res.value      = v;
            if (v == 32'd0) begin
              phase_next = PH_DONE;
              res.last   = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            remaining_next = remaining_next - 32'd1;
            res.valid      = 1'b1;
            res.kind       = KIND_DATA_BYTE;
            res.value      = {24'd0, v[7:0]};
            if (remaining_next == 32'd0) begin
              phase_next = PH_DONE;
              res.last   = 1'b1;
            end
          end
          default: begin
            phase_next = PH_DONE;
          end
        endcase
      end
    end
  end

  // Parse state advances once per accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      skip_count  <= 8'd0;
      bit_count   <= 5'd0;
      bit_shift   <= 32'd0;
      magic_index <= 4'd0;
      magic_ok    <= 1'b1;
      remaining   <= 32'd0;
    end else if (accept) begin
      phase       <= phase_next;
      skip_count  <= skip_count_next;
      bit_count   <= bit_count_next;
      bit_shift   <= bit_shift_next;
      magic_index <= magic_index_next;
      magic_ok    <= magic_ok_next;
      remaining   <= remaining_next;
    end
  end

  // A finished parse stays silent until a new image starts.
  `LSSE_ASSERT_SAME(a_done_silent, clk, rst,
    accept && phase == PH_DONE && !start_of_image, !res.valid,
    "result produced after the end of the payload")
  // Error reports always close the payload.
  `LSSE_ASSERT_SAME(a_error_last, clk, rst,
    res.valid && (res.kind == KIND_MISMATCH || res.kind == KIND_EXT_LONG), res.last,
    "error result without last")
  // A result marked last ends the parse.
  `LSSE_ASSERT_NEXT(a_last_done, clk, rst,
    accept && res.valid && res.last, phase == PH_DONE,
    "parse continues after a last result")

endmodule

FILE: rtl/lsse_out_reg.sv
module lsse_out_reg
  import lsse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  kind,
  output logic [31:0] value,
  output logic        last
);

  kind_t kind_q;

  // Result register: loads on an accepted input, empties when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      kind_q <= res.kind;
      value  <= res.value;
      last   <= res.last;
    end
  end

  assign kind = kind_q;

endmodule

FILE: rtl/lsb_stego_stream_extractor.sv
// A result appears in the cycle after the transaction of the byte that completes it.
// Throughput: one image byte per cycle; the result register frees as it is taken.
// The input stalls only while a result waits and out_ready is low.
// Configuration writes are taken in every cycle (cfg_ready is always high).
// Synchronous reset restores the register defaults and clears the parse state.
module lsb_stego_stream_extractor
  import lsse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  image_byte,
  input  logic        start_of_image,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] value,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t    cfg;
  result_t res;
  logic    in_accept;

  // Accept while the result register is empty or being emptied.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  lsse_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsse_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_accept),
    .image_byte     (image_byte),
    .start_of_image (start_of_image),
    .cfg            (cfg),
    .res            (res)
  );

  lsse_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .kind      (kind),
    .value     (value),
    .last      (last)
  );

endmodule

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lsse_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 360;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned PRINT_LIMIT   = 40;
  localparam int unsigned NO_LIMIT      = 32'hFFFF_FFFF;
  // Index 3 names no register; a write to it must change nothing.
  localparam logic [1:0]  CFG_SPARE     = 2'd3;

  // Parse phases of the extractor.
  typedef enum logic [2:0] {
    PH_HEADER, PH_MAGIC, PH_EXTLEN, PH_EXT, PH_DATALEN, PH_DATA, PH_DONE
  } parse_phase_t;

  // One decoded field as the extractor should report it.
  typedef struct {
    kind_t       kind;
    logic [31:0] value;
    logic        last;
  } token_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  image_byte;
  logic        start_of_image;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  // Decoded fields still to come out of the block, oldest first.
  token_t token_q[$];

  // Mirror of the configuration registers.
  logic [7:0]  hdr_bytes;
  logic [3:0]  mag_len;
  logic [63:0] mag_bytes;

  // Mirror of the parse state.
  parse_phase_t ph;
  logic [7:0]   skip_cnt;
  int unsigned  bit_cnt;
  logic [31:0]  shreg;
  logic [3:0]   mag_idx;
  logic         mag_ok;
  logic [31:0]  remaining;

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned byte_budget;
  logic        sof_pending;
  logic        hold_req;

  lsb_stego_stream_extractor u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .image_byte     (image_byte),
    .start_of_image (start_of_image),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .value          (value),
    .last           (last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Extraction predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_parse();
    ph        = PH_HEADER;
    skip_cnt  = '0;
    bit_cnt   = 0;
    shreg     = '0;
    mag_idx   = '0;
    mag_ok    = 1'b1;
    remaining = '0;
  endfunction

  function automatic logic [3:0] magic_len_used();
    return (mag_len > MAGIC_MAX) ? MAGIC_MAX : mag_len;
  endfunction

  function automatic void expect_token(kind_t k, logic [31:0] v, logic l);
    token_t t;
    t.kind  = k;
    t.value = v;
    t.last  = l;
    token_q.push_back(t);
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [63:0] data);
    case (idx)
      CFG_HEADER_BYTES: hdr_bytes = data[7:0];
      CFG_MAGIC_LENGTH: mag_len   = data[3:0];
      CFG_MAGIC_BYTES:  mag_bytes = data;
      default: ;
    endcase
  endfunction

  // Advance the parse by one accepted image byte.
  function automatic void track_byte(logic [7:0] hb, logic sof);
    logic [3:0]  mlen;
    int unsigned need;
    logic [31:0] word;
    int          sh;
    logic [7:0]  want;
    if (sof) reset_parse();
    if (ph == PH_DONE) return;
    if (ph == PH_HEADER) begin
      if (skip_cnt < hdr_bytes) begin
        skip_cnt = skip_cnt + 8'd1;
        return;
      end
      ph = PH_MAGIC;
    end
    mlen = magic_len_used();
    // The magic check may already be complete when the length was lowered.
    if (ph == PH_MAGIC && mag_idx >= mlen) begin
      if (mlen == 0 && mag_idx == 0) begin
        ph = PH_EXTLEN;
      end else begin
        if (!mag_ok) begin
          ph = PH_DONE;
          expect_token(KIND_MISMATCH, '0, 1'b1);
        end else begin
          ph = PH_EXTLEN;
        end
        return;
      end
    end
    need  = (ph == PH_EXTLEN || ph == PH_DATALEN) ? 32 : 8;
    shreg = {shreg[30:0], hb[0]};
    bit_cnt++;
    if (bit_cnt < need) return;
    word    = shreg;
    shreg   = '0;
    bit_cnt = 0;
    case (ph)
      PH_MAGIC: begin
        sh   = (int'(mlen) - 1 - int'(mag_idx)) * 8;
        want = mag_bytes[sh +: 8];
        if (word[7:0] != want) mag_ok = 1'b0;
        mag_idx = mag_idx + 4'd1;
        if (mag_idx >= mlen) begin
          if (!mag_ok) begin
            ph = PH_DONE;
            expect_token(KIND_MISMATCH, '0, 1'b1);
          end else begin
            ph = PH_EXTLEN;
          end
        end
      end
      PH_EXTLEN: begin
        if (word > EXT_MAX) begin
          ph = PH_DONE;
          expect_token(KIND_EXT_LONG, '0, 1'b1);
        end else begin
          remaining = word;
          ph = (word == 0) ? PH_DATALEN : PH_EXT;
          expect_token(KIND_EXT_LENGTH, word, 1'b0);
        end
      end
      PH_EXT: begin
        remaining = remaining - 32'd1;
        if (remaining == 0) ph = PH_DATALEN;
        expect_token(KIND_EXT_CHAR, {24'd0, word[7:0]}, 1'b0);
      end
      PH_DATALEN: begin
        remaining = word;
        if (word == 0) begin
          ph = PH_DONE;
          expect_token(KIND_DATA_LENGTH, '0, 1'b1);
        end else begin
          ph = PH_DATA;
          expect_token(KIND_DATA_LENGTH, word, 1'b0);
        end
      end
      PH_DATA: begin
        remaining = remaining - 32'd1;
        if (remaining == 0) begin
          ph = PH_DONE;
          expect_token(KIND_DATA_BYTE, {24'd0, word[7:0]}, 1'b1);
        end else begin
          expect_token(KIND_DATA_BYTE, {24'd0, word[7:0]}, 1'b0);
        end
      end
      default: ph = PH_DONE;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_result();
    token_t t;
    if (token_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d value %0h last %0b",
                                kind, value, last));
      return;
    end
    t = token_q.pop_front();
    if (kind !== t.kind)
      report_mismatch($sformatf("kind %0d, expected %0d", kind, t.kind));
    if (value !== t.value)
      report_mismatch($sformatf("value %0h, expected %0h", value, t.value));
    if (last !== t.last)
      report_mismatch($sformatf("last %0b, expected %0b", last, t.last));
  endtask

  // Every transaction on the three channels is observed here at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) track_byte(image_byte, start_of_image);
      if (out_valid && out_ready) check_result();
    end
  end

  // Result receiver: random stalls, or a long hold-off when one is requested.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one image byte and wait for its transaction; returns at a falling edge.
  task automatic send_byte(input logic [7:0] hb, input logic sof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    image_byte     <= hb;
    start_of_image <= sof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Wait until every expected result has arrived and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send one byte of the current image unless its byte budget is spent.
  task automatic next_byte(input logic [7:0] hb);
    if (byte_budget == 0) return;
    byte_budget--;
    send_byte(hb, sof_pending);
    sof_pending = 1'b0;
  endtask

  // Hide the low n bits of val, most significant first, with random upper bits.
  task automatic send_bits(input logic [31:0] val, input int n);
    logic [7:0] hb;
    for (int i = n - 1; i >= 0; i--) begin
      hb    = 8'($urandom);
      hb[0] = val[i];
      next_byte(hb);
    end
  endtask

  task automatic begin_image(input int unsigned budget);
    byte_budget = budget;
    sof_pending = 1'b1;
  endtask

  task automatic send_header();
    repeat (hdr_bytes) next_byte(8'($urandom));
  endtask

  task automatic send_magic(input bit spoil);
    logic [3:0]  mlen;
    logic [7:0]  ch;
    int unsigned bad_idx;
    mlen    = magic_len_used();
    bad_idx = (mlen == 0) ? 0 : $urandom_range(mlen - 1);
    for (int i = 0; i < mlen; i++) begin
      ch = mag_bytes[(int'(mlen) - 1 - i) * 8 +: 8];
      if (spoil && i == bad_idx) ch = ch ^ (8'd1 << $urandom_range(7));
      send_bits({24'd0, ch}, 8);
    end
  endtask

  task automatic send_body(input logic [31:0] ext_len, input logic [31:0] data_len);
    send_bits(ext_len, 32);
    if (ext_len > EXT_MAX) return;
    for (int unsigned i = 0; i < ext_len && byte_budget != 0; i++) send_bits($urandom, 8);
    send_bits(data_len, 32);
    for (int unsigned i = 0; i < data_len && byte_budget != 0; i++) send_bits($urandom, 8);
  endtask

  // A whole carrier image under the current configuration, plus a few trailing bytes.
  task automatic send_image(input logic [31:0] ext_len, input logic [31:0] data_len,
                            input bit spoil, input int unsigned budget);
    begin_image(budget);
    send_header();
    send_magic(spoil);
    send_body(ext_len, data_len);
    byte_budget = NO_LIMIT;
    repeat ($urandom_range(4)) next_byte(8'($urandom));
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic random_config();
    logic [63:0] d;
    logic [7:0]  hdr;
    logic [3:0]  ml;
    d   = {$urandom, $urandom};
    hdr = ($urandom_range(19) == 0) ? 8'd255 : 8'($urandom_range(6));
    d[7:0] = hdr;
    write_reg(CFG_HEADER_BYTES, d);
    d  = {$urandom, $urandom};
    ml = ($urandom_range(4) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    d[3:0] = ml;
    write_reg(CFG_MAGIC_LENGTH, d);
    case ($urandom_range(5))
      0:       d = '0;
      1:       d = '1;
      default: d = {$urandom, $urandom};
    endcase
    write_reg(CFG_MAGIC_BYTES, d);
  endtask

  task automatic random_image();
    int unsigned r;
    logic [31:0] ext_len;
    logic [31:0] data_len;
    r        = $urandom_range(99);
    ext_len  = $urandom_range(EXT_MAX);
    data_len = ($urandom_range(9) == 0) ? 32'd40 : 32'($urandom_range(12));
    if (r < 65) begin
      send_image(ext_len, data_len, 1'b0, NO_LIMIT);
    end else if (r < 75) begin
      send_image(ext_len, data_len, 1'b1, NO_LIMIT);
    end else if (r < 82) begin
      ext_len = $urandom_range(1) ? (EXT_MAX + 1 + $urandom_range(1000))
                                  : ($urandom | 32'h8000_0000);
      send_image(ext_len, data_len, 1'b0, NO_LIMIT);
    end else if (r < 92) begin
      // Broken image: cut short, the next image restarts the parse.
      send_image(ext_len, data_len, 1'($urandom_range(1)),
                 $urandom_range(hdr_bytes + 120, 1));
    end else begin
      repeat ($urandom_range(60, 10)) send_byte(8'($urandom), $urandom_range(9) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset: 54 header bytes and the two-character magic.
  task automatic test_reset_config();
    send_image(32'd2, 32'd3, 1'b0, NO_LIMIT);
  endtask

  // No header and no magic: hidden bits start with the very first byte.
  task automatic test_zero_header_no_magic();
    write_reg(CFG_HEADER_BYTES, 64'd0);
    write_reg(CFG_MAGIC_LENGTH, 64'd0);
    send_image(32'd0, 32'd0, 1'b0, NO_LIMIT);
    send_image(EXT_MAX, 32'd1, 1'b0, NO_LIMIT);
  endtask

  // Full-length magic with a spoiled character, and a length clamped to the maximum.
  task automatic test_magic_check();
    write_reg(CFG_HEADER_BYTES, 64'd1);
    write_reg(CFG_MAGIC_LENGTH, 64'd8);
    write_reg(CFG_MAGIC_BYTES, '1);
    send_image(32'd1, 32'd1, 1'b1, NO_LIMIT);
    write_reg(CFG_MAGIC_BYTES, 64'h0123_4567_89AB_CDEF);
    write_reg(CFG_MAGIC_LENGTH, 64'd15);
    write_reg(CFG_SPARE, '1);
    send_image(32'd1, 32'd2, 1'b0, NO_LIMIT);
  endtask

  // Extension lengths just above the bound and at the top of the range.
  task automatic test_ext_too_long();
    write_reg(CFG_HEADER_BYTES, 64'd2);
    write_reg(CFG_MAGIC_LENGTH, 64'd1);
    send_image(EXT_MAX + 32'd1, 32'd1, 1'b0, NO_LIMIT);
    send_image(32'hFFFF_FFFF, 32'd1, 1'b0, NO_LIMIT);
  endtask

  // The header count is lowered below the bytes already skipped.
  task automatic test_mid_skip_header();
    write_reg(CFG_HEADER_BYTES, 64'd20);
    begin_image(NO_LIMIT);
    repeat (10) next_byte(8'($urandom));
    write_reg(CFG_HEADER_BYTES, 64'd5);
    send_magic(1'b0);
    send_body(32'd1, 32'd1);
  endtask

  // The magic length is lowered after two characters, with and without an error.
  task automatic test_magic_len_lowered();
    write_reg(CFG_HEADER_BYTES, 64'd0);
    write_reg(CFG_MAGIC_BYTES, 64'h1122_3344);
    write_reg(CFG_MAGIC_LENGTH, 64'd4);
    begin_image(NO_LIMIT);
    send_bits(32'h11, 8);
    send_bits(32'h22, 8);
    write_reg(CFG_MAGIC_LENGTH, 64'd1);
    next_byte(8'($urandom));
    send_body(32'd1, 32'd2);
    write_reg(CFG_MAGIC_LENGTH, 64'd4);
    begin_image(NO_LIMIT);
    send_bits(32'h10, 8);
    send_bits(32'h22, 8);
    write_reg(CFG_MAGIC_LENGTH, 64'd1);
    next_byte(8'($urandom));
    repeat (3) next_byte(8'($urandom));
  endtask

  // A new image starts in the middle of a huge data run and of a header.
  task automatic test_restart();
    write_reg(CFG_HEADER_BYTES, 64'd3);
    write_reg(CFG_MAGIC_LENGTH, 64'd2);
    send_image(32'd0, 32'hFFFF_FFFF, 1'b0, 3 + 16 + 64 + 20);
    send_image(32'd1, 32'd1, 1'b0, 2);
    send_image(32'd1, 32'd1, 1'b0, NO_LIMIT);
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    goal = items_sent;
    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0:       set_idling(21, 58);
        1:       set_idling(58, 21);
        default: set_idling(0, 0);
      endcase
      goal = goal + RANDOM_ITEMS / 3;
      while (items_sent < goal) begin
        if ($urandom_range(3) == 0) random_config();
        random_image();
      end
    end
  endtask

  // The receiver holds off while bytes keep coming, then the sender waits for all results.
  task automatic test_backpressure();
    set_idling(0, 0);
    write_reg(CFG_HEADER_BYTES, 64'd0);
    write_reg(CFG_MAGIC_LENGTH, 64'd0);
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    send_image(EXT_MAX, 32'd8, 1'b0, NO_LIMIT);
    settle();
    send_image(32'd3, 32'd5, 1'b0, NO_LIMIT);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : main
    int unsigned n;
    rst            = 1'b1;
    in_valid       = 1'b0;
    image_byte     = '0;
    start_of_image = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    hold_req       = 1'b0;
    mismatches     = 0;
    items_sent     = 0;
    byte_budget    = NO_LIMIT;
    sof_pending    = 1'b0;
    hdr_bytes      = HEADER_BYTES_RESET;
    mag_len        = MAGIC_LENGTH_RESET;
    mag_bytes      = MAGIC_BYTES_RESET;
    reset_parse();
    set_idling(21, 58);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_config();
    test_zero_header_no_magic();
    test_magic_check();
    test_ext_too_long();
    test_mid_skip_header();
    test_magic_len_lowered();
    test_restart();
    test_random_traffic();
    test_backpressure();

    // Drain whatever is still in flight.
    in_valid <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && token_q.size() != 0; n++) @(negedge clk);
    repeat (SETTLE_CYCLES * 4) @(negedge clk);
    if (token_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", token_q.size()));
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
